// ===== rtl/rmts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Rate-monotonic tick scheduler package
// Shared widths, link types and helper functions for the scheduler cells.
// ---------------------------------------------------------------------------
package rmts_pkg;

   // Fixed field widths.
   localparam int DATA_W      = 16;
   localparam int TASK_IDX_W  = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int MAX_TASKS   = 4;
   localparam int NUM_TASKS_DEF = 4;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;

   // Configuration register kinds, selected by the lowest index bit.
   localparam logic CSR_KIND_PERIOD = 1'b0;
   localparam logic CSR_KIND_BURST  = 1'b1;

   // Best candidate found so far, handed from cell to cell.
   typedef struct packed {
      logic                  valid;
      logic [TASK_IDX_W-1:0] idx;
      logic [DATA_W-1:0]     period;
   } link_type;

   // Winner of the priority chain, broadcast back to every cell.
   typedef struct packed {
      logic                  valid;
      logic [TASK_IDX_W-1:0] idx;
   } sel_type;

   // Configuration write, seen by every cell.
   typedef struct packed {
      logic                  wen;
      logic [CSR_IDX_W-1:0]  index;
      logic [DATA_W-1:0]     wdata;
   } csr_wr_type;

   // A zero period or burst acts as one.
   function automatic logic [DATA_W-1:0] eff_value(input logic [DATA_W-1:0] v);
      eff_value = (v == '0) ? DATA_W'(1) : v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rate_monotonic_tick_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Latency: the result of a tick is registered and presented in the cycle after the item is accepted.
// Throughput: one tick per cycle unless rsp_tready stalls the output; the priority chain
// through the task cells settles within the accepting cycle, and the output register frees req_tready.
// Reset (synchronous, active high) clears all countdowns, pending flags and unit
// counts, sets every period and burst register to one and empties the output.
// ---------------------------------------------------------------------------
// Rate-monotonic tick scheduler core
// A row of task cells resolves releases and the shortest-period winner for
// each tick item and registers one result item per tick.
// ---------------------------------------------------------------------------
module rate_monotonic_tick_scheduler_core #(
   parameter int NUM_TASKS = rmts_pkg::NUM_TASKS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   // Tick channel. tdata: [0] restart, [7:1] zero.
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [rmts_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Result channel. tdata: [1:0] running_task, [2] idle, [3] completed,
   // [7:4] missed_mask.
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [rmts_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Configuration write port.
   input  wire                                csr_wen,
   input  wire  [rmts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [rmts_pkg::DATA_W-1:0]        csr_wdata
);

   rmts_pkg::link_type   link [0:NUM_TASKS];
   rmts_pkg::sel_type    sel;
   rmts_pkg::csr_wr_type csr_wr;
   logic [NUM_TASKS-1:0]           done_vec;
   logic [rmts_pkg::MAX_TASKS-1:0] missed_vec;
   logic                           accept, restart, completed, idle;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rmts_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Input handshake: take a tick whenever the output register can be refilled.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign restart    = req_tdata[0];

   assign csr_wr.wen   = csr_wen;
   assign csr_wr.index = csr_index;
   assign csr_wr.wdata = csr_wdata;

   // Row of task cells; the chain starts with no candidate.
   assign link[0] = '0;

   for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
      rmts_cell #(.IDX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .restart    (restart),
         .csr_wr     (csr_wr),
         .link_in    (link[i]),
         .link_out   (link[i+1]),
         .sel        (sel),
         .done_out   (done_vec[i]),
         .missed_out (missed_vec[i])
      );
   end

   for (genvar j = NUM_TASKS; j < rmts_pkg::MAX_TASKS; j++) begin : g_unused
      assign missed_vec[j] = 1'b0;
   end

   // Winner of the chain goes back to all cells.
   assign sel.valid = link[NUM_TASKS].valid;
   assign sel.idx   = link[NUM_TASKS].valid ? link[NUM_TASKS].idx : '0;

   assign completed = |done_vec;
   assign idle      = !sel.valid;

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {missed_vec, completed, idle, sel.idx};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/rmts_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Scheduler task cell
// Holds one task's configuration, release countdown, pending flag and unit
// count, and takes part in the shortest-period priority chain.
// ---------------------------------------------------------------------------
module rmts_cell #(
   parameter int IDX = 0
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        accept,
   input  wire                        restart,
   input  wire rmts_pkg::csr_wr_type  csr_wr,
   input  wire rmts_pkg::link_type    link_in,
   output rmts_pkg::link_type         link_out,
   input  wire rmts_pkg::sel_type     sel,
   output logic                       done_out,
   output logic                       missed_out
);

   localparam logic [rmts_pkg::TASK_IDX_W-1:0] MY_IDX = rmts_pkg::TASK_IDX_W'(IDX);

   logic [rmts_pkg::DATA_W-1:0] period_ff, period_in;
   logic [rmts_pkg::DATA_W-1:0] burst_ff, burst_in;
   logic [rmts_pkg::DATA_W-1:0] countdown_ff, countdown_in;
   logic [rmts_pkg::DATA_W-1:0] units_ff, units_in;
   logic                        pending_ff, pending_in;

   logic [rmts_pkg::DATA_W-1:0] eff_p, eff_b;
   logic [rmts_pkg::DATA_W-1:0] cd_cur, units_cur, units_rel;
   logic                        pend_cur, pend_rel, release_now;
   logic [rmts_pkg::DATA_W:0]   units_inc;
   logic                        run, finish;

   assign eff_p = rmts_pkg::eff_value(period_ff);
   assign eff_b = rmts_pkg::eff_value(burst_ff);

   // A restart tick sees all task state as cleared.
   assign cd_cur    = restart ? '0   : countdown_ff;
   assign pend_cur  = restart ? 1'b0 : pending_ff;
   assign units_cur = restart ? '0   : units_ff;

   // Release phase.
   assign release_now = (cd_cur == '0);
   assign missed_out  = release_now && pend_cur;
   assign pend_rel    = release_now || pend_cur;
   assign units_rel   = release_now ? '0 : units_cur;

   // Priority chain: a strictly shorter period displaces earlier candidates.
   always_comb begin
      link_out = link_in;
      if (pend_rel && (!link_in.valid || (eff_p < link_in.period))) begin
         link_out.valid  = 1'b1;
         link_out.idx    = MY_IDX;
         link_out.period = eff_p;
      end
   end

   // Execute one unit when this cell won the chain.
   assign run       = sel.valid && (sel.idx == MY_IDX);
   assign units_inc = {1'b0, units_rel} + (rmts_pkg::DATA_W+1)'(1);
   assign finish    = units_inc >= {1'b0, eff_b};
   assign done_out  = run && finish;

   // Next state.
   always_comb begin
      period_in    = period_ff;
      burst_in     = burst_ff;
      countdown_in = countdown_ff;
      pending_in   = pending_ff;
      units_in     = units_ff;
      if (csr_wr.wen && (csr_wr.index[rmts_pkg::CSR_IDX_W-1:1] == MY_IDX)) begin
         if (csr_wr.index[0] == rmts_pkg::CSR_KIND_BURST) begin
            burst_in = csr_wr.wdata;
         end else begin
            period_in = csr_wr.wdata;
         end
      end
      if (accept) begin
         countdown_in = release_now ? (eff_p - rmts_pkg::DATA_W'(1))
                                    : (cd_cur - rmts_pkg::DATA_W'(1));
         pending_in   = pend_rel;
         units_in     = units_rel;
         if (run) begin
            if (finish) begin
               pending_in = 1'b0;
               units_in   = '0;
            end else begin
               units_in = units_inc[rmts_pkg::DATA_W-1:0];
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= rmts_pkg::DATA_W'(1);
         burst_ff     <= rmts_pkg::DATA_W'(1);
         countdown_ff <= '0;
         pending_ff   <= 1'b0;
         units_ff     <= '0;
      end else begin
         period_ff    <= period_in;
         burst_ff     <= burst_in;
         countdown_ff <= countdown_in;
         pending_ff   <= pending_in;
         units_ff     <= units_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rmts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Scheduler port checker
// Watches the scheduler ports for consistent results and handshake behavior.
// ---------------------------------------------------------------------------
module rmts_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   input  wire                             req_tready,
   input  wire [rmts_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire                             rsp_tvalid,
   input  wire                             rsp_tready,
   input  wire [rmts_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // An idle result names task zero and reports no completion.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |-> (rsp_tdata[1:0] == '0 && !rsp_tdata[3]))
      else $error("idle result carries a task or completion");

   // A restart tick releases every task fresh: nothing missed, something runs.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[0]) |=>
         (rsp_tvalid && rsp_tdata[7:4] == '0 && !rsp_tdata[2]))
      else $error("restart tick result is wrong");

   // An empty output stage always takes a tick.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while the output is empty");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind rate_monotonic_tick_scheduler_core rmts_checker u_rmts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
